[src/escaped_frame_encoder_fcs16_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the escaped frame encoder
// Clocked property checks that are used by the back RTL file.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_FRAME_ENCODER_FCS16_UNIT_ASSERT_SVH
`define ESCAPED_FRAME_ENCODER_FCS16_UNIT_ASSERT_SVH

// Check a property on every rising edge outside reset
`define EFE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check an implication on every rising edge outside reset
`define EFE_ASSERT_IMPL(label, ante, cons, msg) \
  `EFE_ASSERT(label, (ante) |-> (cons), msg)

// Check that a condition is followed by another in the next cycle
`define EFE_ASSERT_NEXT(label, ante, cons, msg) \
  `EFE_ASSERT(label, (ante) |=> (cons), msg)

`endif

[src/efe_pkg.sv]
// ----------------------------------------------------------------------------
// Escaped frame encoder package
// Shared types, line codes and the FCS-16 byte update.
// ----------------------------------------------------------------------------
package efe_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7e;
  localparam logic [7:0]  ESC_BYTE  = 8'h7d;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] FCS_POLY  = 16'h8408;
  localparam logic [15:0] FCS_RESET = 16'hffff;

  // Job queue between the front and the back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified word as it travels to the back
  typedef struct packed {
    logic        open_flag;
    logic [7:0]  data;
    logic        last;
    logic [15:0] fcs;
  } job_t;

  // Bytes that must not appear raw on the line
  function automatic logic needs_escape(input logic [7:0] b);
    return (b == 8'h7d) || (b == 8'h7e) || (b == 8'h11) || (b == 8'h12) || (b == 8'h13);
  endfunction

  // Reflected CRC-16 update over one byte, LSB first
  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] c;
    c = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FCS_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[src/efe_queue.sv]
// ----------------------------------------------------------------------------
// Escaped frame encoder job queue
// Small first-in first-out store of classified words in flip-flops.
// ----------------------------------------------------------------------------
module efe_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en_i,
  input  efe_pkg::job_t wr_job_i,
  output logic          full_o,
  input  logic          rd_en_i,
  output efe_pkg::job_t rd_job_o,
  output logic          valid_o
);
  import efe_pkg::*;

  job_t                   mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;
  logic                   do_wr, do_rd;

  assign full_o   = (count_r == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign valid_o  = (count_r != '0);
  assign rd_job_o = mem_r[rd_ptr_r];
  assign do_wr    = wr_en_i && !full_o;
  assign do_rd    = rd_en_i && valid_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job_i;
    end
  end

endmodule

[src/efe_front.sv]
// ----------------------------------------------------------------------------
// Escaped frame encoder front
// Accepts body bytes, tracks frame state, runs the FCS and queues jobs.
// ----------------------------------------------------------------------------
module efe_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  input  logic          in_push,
  output logic          in_full,
  input  logic [7:0]    in_data_byte,
  input  logic          in_first_byte,
  input  logic          in_last_byte,
  output logic          job_wr_o,
  output efe_pkg::job_t job_o,
  input  logic          queue_full_i
);
  import efe_pkg::*;

  logic [15:0] fcs_init_r;
  logic [15:0] running_fcs_r, running_fcs_nxt;
  logic        frame_open_r, frame_open_nxt;
  logic        accept;
  logic        in_frame;
  logic [15:0] fcs_base;
  logic [15:0] fcs_new;

  assign in_full  = queue_full_i;
  assign accept   = in_push && !queue_full_i;
  assign in_frame = in_first_byte || frame_open_r;
  assign fcs_base = in_first_byte ? fcs_init_r : running_fcs_r;
  assign fcs_new  = fcs_update(fcs_base, in_data_byte);

  // Classify the word; drop it when no frame is open
  assign job_wr_o       = accept && in_frame;
  assign job_o.open_flag = in_first_byte;
  assign job_o.data      = in_data_byte;
  assign job_o.last      = in_last_byte;
  assign job_o.fcs       = fcs_new ^ FCS_RESET;

  always_comb begin
    running_fcs_nxt = running_fcs_r;
    frame_open_nxt  = frame_open_r;
    if (accept && in_frame) begin
      running_fcs_nxt = fcs_new;
      frame_open_nxt  = !in_last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcs_init_r    <= FCS_RESET;
      running_fcs_r <= FCS_RESET;
      frame_open_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fcs_init_r <= cfg_wr_data;
      end
      running_fcs_r <= running_fcs_nxt;
      frame_open_r  <= frame_open_nxt;
    end
  end

endmodule

[src/efe_back.sv]
// ----------------------------------------------------------------------------
// Escaped frame encoder back
// Walks each queued job byte by byte and drives the line byte register.
// ----------------------------------------------------------------------------
module efe_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid_i,
  input  efe_pkg::job_t head_i,
  output logic          head_pop_o,
  output logic          out_empty,
  input  logic          out_pop,
  output logic [7:0]    out_byte,
  output logic          out_run_end
);
  import efe_pkg::*;

  `include "escaped_frame_encoder_fcs16_unit_assert.svh"

  localparam logic [2:0] PH_OPEN   = 3'd0;
  localparam logic [2:0] PH_DATA   = 3'd1;
  localparam logic [2:0] PH_FCS_LO = 3'd2;
  localparam logic [2:0] PH_FCS_HI = 3'd3;
  localparam logic [2:0] PH_CLOSE  = 3'd4;

  logic [2:0] phase_r, phase_nxt;
  logic       esc_r, esc_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_run_end_r, out_run_end_nxt;
  logic [2:0] cur_phase;
  logic [7:0] raw_byte;
  logic       escapable;
  logic       adv, emit;
  logic       step_done;
  logic       job_done;
  logic [2:0] next_phase;

  assign adv  = !out_valid_r || out_pop;
  assign emit = adv && head_valid_i;

  // Skip the opening flag when the job does not start a frame
  assign cur_phase = (phase_r == PH_OPEN && !head_i.open_flag) ? PH_DATA : phase_r;

  // Pick the raw byte of the current phase and where to go next
  always_comb begin
    raw_byte   = FLAG_BYTE;
    escapable  = 1'b0;
    next_phase = PH_OPEN;
    job_done   = 1'b0;
    unique case (cur_phase)
      PH_OPEN: begin
        next_phase = PH_DATA;
      end
      PH_DATA: begin
        raw_byte   = head_i.data;
        escapable  = 1'b1;
        next_phase = PH_FCS_LO;
        job_done   = !head_i.last;
      end
      PH_FCS_LO: begin
        raw_byte   = head_i.fcs[7:0];
        escapable  = 1'b1;
        next_phase = PH_FCS_HI;
      end
      PH_FCS_HI: begin
        raw_byte   = head_i.fcs[15:8];
        escapable  = 1'b1;
        next_phase = PH_CLOSE;
      end
      PH_CLOSE: begin
        job_done = 1'b1;
      end
      default: begin
        job_done = 1'b1;
      end
    endcase
  end

  // Emit escape first, then the flipped byte
  always_comb begin
    phase_nxt       = phase_r;
    esc_nxt         = esc_r;
    out_byte_nxt    = out_byte_r;
    out_run_end_nxt = out_run_end_r;
    out_valid_nxt   = out_pop ? 1'b0 : out_valid_r;
    step_done       = 1'b0;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (escapable && needs_escape(raw_byte) && !esc_r) begin
        out_byte_nxt = ESC_BYTE;
        esc_nxt      = 1'b1;
      end else begin
        out_byte_nxt = esc_r ? (raw_byte ^ ESC_XOR) : raw_byte;
        esc_nxt      = 1'b0;
        step_done    = 1'b1;
      end
      out_run_end_nxt = step_done && job_done;
      if (step_done) begin
        phase_nxt = job_done ? PH_OPEN : next_phase;
      end
    end
  end

  assign head_pop_o  = emit && step_done && job_done;
  assign out_empty   = !out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_run_end = out_run_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPEN;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the line byte until taken
  always_ff @(posedge clk) begin
    out_byte_r    <= out_byte_nxt;
    out_run_end_r <= out_run_end_nxt;
  end

  `EFE_ASSERT_NEXT(a_pop_marks_end, head_pop_o, out_valid_r && out_run_end_r, "job retired without run end")
  `EFE_ASSERT_IMPL(a_mid_job_has_head, phase_r != PH_OPEN || esc_r, head_valid_i, "job state without queued job")
  `EFE_ASSERT_IMPL(a_escaped_is_clean, emit && esc_r, !needs_escape(out_byte_nxt), "escaped byte still needs escape")

endmodule

[src/escaped_frame_encoder_fcs16_unit.sv]
// ----------------------------------------------------------------------------
// Escaped frame encoder with FCS-16
// PPP style asynchronous framing of body bytes with escaping and FCS.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: push a body word (in_data_byte with in_first_byte and
//   in_last_byte marks) while in_full is low. A word without a first mark
//   outside an open frame is dropped. A first mark opens a new frame, even
//   over an unfinished one.
//   Result channel: while out_empty is low, out_byte holds the next line
//   byte; out_run_end marks the last byte caused by one input word. Raise
//   out_pop to take it.
//   Configuration: cfg_wr_en with cfg_wr_data sets the FCS start value; write
//   only while the block is idle.
//   Path: each accepted word is queued, then its line bytes pass the output register.
//   Throughput: one line byte per cycle while out_pop stays high and jobs wait,
//   set by the single output register; a word causes one to eight line bytes
//   (flag, escaped byte, two escaped FCS bytes, flag), three at most for a body word that is not last.
//   A four-entry job queue parts the front from the back, so input keeps
//   flowing while the receiver stalls; in_full rises once the queue fills.
//   Reset: the FCS start value returns to 0xffff, no frame is open and all
//   queued and pending bytes are discarded.
// ----------------------------------------------------------------------------
module escaped_frame_encoder_fcs16_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_run_end
);
  import efe_pkg::*;

  job_t wr_job;
  job_t head_job;
  logic job_wr;
  logic queue_full;
  logic head_valid;
  logic head_pop;

  // Accept and classify words
  efe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_byte (in_data_byte),
    .in_first_byte(in_first_byte),
    .in_last_byte (in_last_byte),
    .job_wr_o     (job_wr),
    .job_o        (wr_job),
    .queue_full_i (queue_full)
  );

  // Buffer jobs between the two sides
  efe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en_i (job_wr),
    .wr_job_i(wr_job),
    .full_o  (queue_full),
    .rd_en_i (head_pop),
    .rd_job_o(head_job),
    .valid_o (head_valid)
  );

  // Serialize jobs onto the line
  efe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid_i(head_valid),
    .head_i      (head_job),
    .head_pop_o  (head_pop),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_byte    (out_byte),
    .out_run_end (out_run_end)
  );

endmodule

[tb/sv/tb_escaped_frame_encoder_fcs16_unit.sv]
// ----------------------------------------------------------------------------
// Testbench for the escaped frame encoder with FCS-16
// Drives frame body words through the push/full side and scores every line
// word popped on the result side against an in-bench encoder. Covers edge
// bytes, escaped data and FCS bytes, dropped, abandoned and one-byte frames,
// several FCS start values, and random traffic under sender and receiver
// stalls.
// ----------------------------------------------------------------------------
module tb_escaped_frame_encoder_fcs16_unit;
  import efe_pkg::FLAG_BYTE;
  import efe_pkg::ESC_BYTE;
  import efe_pkg::ESC_XOR;

  localparam logic [7:0]  DC1_BYTE    = 8'h11;
  localparam logic [7:0]  DC2_BYTE    = 8'h12;
  localparam logic [7:0]  DC3_BYTE    = 8'h13;
  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [15:0] START_RESET = 16'hffff;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          SETTLE_CYCLES = 16;

  typedef struct {
    logic [7:0] data;
    logic       run_end;
  } line_word_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_push;
  logic        in_full;
  logic [7:0]  in_data_byte;
  logic        in_first_byte;
  logic        in_last_byte;
  logic        out_empty;
  logic        out_pop;
  logic [7:0]  out_byte;
  logic        out_run_end;

  // Encoder state as the bench sees it
  logic [15:0] fcs_start;
  logic [15:0] fcs_acc;
  logic        frame_is_open;
  line_word_t  line_bytes_due[$];
  line_word_t  word_burst[$];
  line_word_t  popped_due;

  int error_count;
  int cycle_count;
  int body_words_taken;
  int send_idle_pct;
  int pop_stall_pct;

  escaped_frame_encoder_fcs16_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_data_byte (in_data_byte),
    .in_first_byte(in_first_byte),
    .in_last_byte (in_last_byte),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_byte     (out_byte),
    .out_run_end  (out_run_end)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Encoder predictor
  // ---------------------------------------------------------------------------

  // Shift one byte through the reflected CRC, one bit at a time
  function automatic logic [15:0] fcs16_step(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ d[i];
      r = {1'b0, r[15:1]};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic logic is_control_byte(input logic [7:0] b);
    case (b)
      ESC_BYTE, FLAG_BYTE, DC1_BYTE, DC2_BYTE, DC3_BYTE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic burst_raw(input logic [7:0] b);
    line_word_t w;
    w.data = b;
    w.run_end = 1'b0;
    word_burst.push_back(w);
  endtask

  task automatic burst_escaped(input logic [7:0] b);
    if (is_control_byte(b)) begin
      burst_raw(ESC_BYTE);
      burst_raw(b ^ ESC_XOR);
    end else begin
      burst_raw(b);
    end
  endtask

  // Work out the line words caused by one accepted body word
  task automatic encode_word(input logic [7:0] b, input logic first, input logic last);
    logic [15:0] fcs_out;
    word_burst.delete();
    if (first) begin
      burst_raw(FLAG_BYTE);
      fcs_acc = fcs_start;
      frame_is_open = 1'b1;
    end
    if (frame_is_open) begin
      body_words_taken++;
      fcs_acc = fcs16_step(fcs_acc, b);
      burst_escaped(b);
      if (last) begin
        fcs_out = ~fcs_acc;
        burst_escaped(fcs_out[7:0]);
        burst_escaped(fcs_out[15:8]);
        burst_raw(FLAG_BYTE);
        frame_is_open = 1'b0;
      end
      word_burst[word_burst.size() - 1].run_end = 1'b1;
      foreach (word_burst[i]) begin
        line_bytes_due.push_back(word_burst[i]);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Drivers and result check
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Push one body word; enter and leave at a falling edge
  task automatic send_word(input logic [7:0] b, input logic first, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_data_byte = b;
    in_first_byte = first;
    in_last_byte = last;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    encode_word(b, first, last);
    @(negedge clk);
  endtask

  // Hold off until every due line word has been popped, then let the block settle
  task automatic drain_and_settle();
    in_push = 1'b0;
    while (line_bytes_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_fcs_start(input logic [15:0] value);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    fcs_start = value;
  endtask

  // Randomize pop at every falling edge
  always @(negedge clk) begin
    out_pop = ($urandom_range(0, 99) >= pop_stall_pct);
  end

  // Score each popped line word against the oldest due one
  always @(posedge clk) begin
    if (rst_n && !out_empty && out_pop) begin
      if (line_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected line word %02h run_end %b",
                                  out_byte, out_run_end));
      end else begin
        popped_due = line_bytes_due.pop_front();
        if (out_byte !== popped_due.data) begin
          report_mismatch($sformatf("out_byte %02h, want %02h", out_byte, popped_due.data));
        end
        if (out_run_end !== popped_due.run_end) begin
          report_mismatch($sformatf("out_run_end %b, want %b (byte %02h)",
                                    out_run_end, popped_due.run_end, popped_due.data));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Edge bytes and every control byte as one-byte frames
  task automatic test_single_byte_frames();
    logic [7:0] picks[8];
    picks = '{8'h00, 8'hff, ESC_BYTE, FLAG_BYTE, DC1_BYTE, DC2_BYTE, DC3_BYTE, 8'h5e};
    foreach (picks[i]) begin
      send_word(picks[i], 1'b1, 1'b1);
    end
  endtask

  // Drop words outside a frame, then send a clean frame around near-miss bytes
  task automatic test_stray_words();
    send_word(FLAG_BYTE, 1'b0, 1'b1);
    send_word(8'h55, 1'b0, 1'b0);
    send_word(8'h10, 1'b1, 1'b0);
    send_word(8'h14, 1'b0, 1'b0);
    send_word(8'h7f, 1'b0, 1'b1);
  endtask

  // Restart over an open frame without closing it
  task automatic test_abandoned_frame();
    send_word(8'h7c, 1'b1, 1'b0);
    send_word(8'haa, 1'b0, 1'b0);
    send_word(8'h5d, 1'b1, 1'b0);
    send_word(8'h31, 1'b0, 1'b1);
  endtask

  // Pick a start value so both FCS bytes need escaping, for the longest burst
  task automatic test_escaped_fcs();
    logic [15:0] fcs_out;
    logic [15:0] pick;
    pick = 16'h0000;
    for (int s = 0; s < 65536; s++) begin
      fcs_out = ~fcs16_step(s[15:0], FLAG_BYTE);
      if (is_control_byte(fcs_out[7:0]) && is_control_byte(fcs_out[15:8])) begin
        pick = s[15:0];
        break;
      end
    end
    drain_and_settle();
    write_fcs_start(pick);
    send_word(FLAG_BYTE, 1'b1, 1'b1);
    send_word(ESC_BYTE, 1'b1, 1'b1);
    drain_and_settle();
    write_fcs_start(16'h0000);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hff, 1'b0, 1'b1);
  endtask

  // Body byte biased toward the bytes that need escaping
  function automatic logic [7:0] pick_body_byte();
    case ($urandom_range(0, 9))
      0: return ESC_BYTE;
      1: return FLAG_BYTE;
      2: return 8'h11 + 8'($urandom_range(0, 2));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly whole frames, some stray words and abandoned frames
  task automatic test_random_frames(input int send_pct, input int pop_pct,
                                    input logic [15:0] start, input int word_target);
    int stop_at;
    int len;
    int kind;
    drain_and_settle();
    write_fcs_start(start);
    send_idle_pct = send_pct;
    pop_stall_pct = pop_pct;
    stop_at = body_words_taken + word_target;
    while (body_words_taken < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        send_word(pick_body_byte(), 1'b0, 1'($urandom_range(0, 1)));
      end else begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
        for (int i = 0; i < len; i++) begin
          send_word(pick_body_byte(), i == 0, (kind >= 18) && (i == len - 1));
        end
      end
    end
    drain_and_settle();
    send_idle_pct = 0;
    pop_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 16'h0000;
    in_push = 1'b0;
    in_data_byte = 8'h00;
    in_first_byte = 1'b0;
    in_last_byte = 1'b0;
    out_pop = 1'b0;
    error_count = 0;
    cycle_count = 0;
    body_words_taken = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    fcs_start = START_RESET;
    fcs_acc = START_RESET;
    frame_is_open = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_single_byte_frames();
    test_stray_words();
    test_abandoned_frame();
    test_escaped_fcs();
    test_random_frames(0, 0, START_RESET, 36);
    test_random_frames(86, 0, 16'($urandom_range(0, 65535)), 36);
    test_random_frames(0, 86, 16'h0000, 36);
    test_random_frames(20, 20, 16'($urandom_range(0, 65535)), 36);

    drain_and_settle();
    if (error_count == 0) begin
      $display("escaped_frame_encoder_fcs16_unit test passed");
    end else begin
      $display("escaped_frame_encoder_fcs16_unit test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("escaped_frame_encoder_fcs16_unit test failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/efe_pkg.sv
src/efe_queue.sv
src/efe_front.sv
src/efe_back.sv
src/escaped_frame_encoder_fcs16_unit.sv
tb/sv/tb_escaped_frame_encoder_fcs16_unit.sv
